FILE: rtl/drtp_pkg.sv
// shared types and constants for the depth record top-3 projector
// no dependencies
`default_nettype none
package drtp_pkg;
  localparam int MaxRecordsDef = 1000;
  localparam int TopRanksDef = 3;
  localparam int IdxW = 10;
  localparam int RankW = 2;

  typedef enum logic {KIND_RECORD = 1'b0, KIND_RANK = 1'b1} kind_t;

  typedef struct packed {
    logic            is_end;
    logic [63:0]     price_bits;
    logic [31:0]     volume;
    logic [15:0]     auxiliary;
  } cmd_t;

  typedef struct packed {
    kind_t           kind;
    logic [31:0]     price_single_bits;
    logic [31:0]     volume_out;
    logic [15:0]     auxiliary_out;
    logic [IdxW-1:0] record_index;
    logic [RankW-1:0] rank;
    logic            last;
  } res_t;

  function automatic logic [31:0] to_single(input logic [63:0] b);
    logic        s;
    logic [10:0] ex;
    logic [51:0] fr;
    logic [52:0] m;
    logic [12:0] e;
    logic [24:0] keep;
    logic [28:0] rem;
    logic [6:0]  sh;
    logic [52:0] kp;
    logic [52:0] msk;
    logic [52:0] rm;
    logic [52:0] hf;
    logic [31:0] r;
    s = b[63];
    ex = b[62:52];
    fr = b[51:0];
    m = {1'b1, fr};
    e = {2'b00, ex} - 13'd896;
    r = {s, 31'd0};
    if (ex == 11'h7ff) begin
      if (fr == 52'd0) r = {s, 31'h7f800000};
      else r = {s, 31'h7fc00000} | {9'd0, fr[51:29]};
    end else if (ex == 11'd0) begin
      r = {s, 31'd0};
    end else if (!e[12] && e >= 13'd255) begin
      r = {s, 31'h7f800000};
    end else if (!e[12] && e != 13'd0) begin
      keep = {1'b0, m[52:29]};
      rem = m[28:0];
      if (rem > 29'h10000000 || (rem == 29'h10000000 && keep[0])) keep = keep + 25'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        e = e + 13'd1;
      end
      if (e >= 13'd255) r = {s, 31'h7f800000};
      else r = {s, e[7:0], keep[22:0]};
    end else begin
      // subnormal result: shift = 30 - e, e <= 0
      // shifts past 53 leave less than half an lsb, so the result is a signed zero
      if (ex < 11'd873) begin
        r = {s, 31'd0};
      end else begin
        sh = 7'(13'd30 - e);
        kp = m >> sh;
        msk = (53'd1 << sh) - 53'd1;
        rm = m & msk;
        hf = 53'd1 << (sh - 7'd1);
        if (rm > hf || (rm == hf && kp[0])) kp = kp + 53'd1;
        r = {s, kp[30:0]};
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/drtp_front.sv
// front end: accepts beats, converts prices, keeps the running top list
// depends on drtp_pkg
`default_nettype none
module drtp_front
  import drtp_pkg::*;
#(
  parameter int MAX_RECORDS = MaxRecordsDef,
  parameter int TOP_RANKS = TopRanksDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  cmd_t      in_cmd,
  output logic      q_push,
  output res_t      q_data,
  input  wire logic q_room
);
  logic [IdxW-1:0]  seen_r, seen_nxt;
  logic [31:0]      vol_r [3];
  logic [IdxW-1:0]  idx_r [3];
  logic [1:0]       fill_r, fill_nxt;
  logic [31:0]      vol_nxt [3];
  logic [IdxW-1:0]  idx_nxt [3];
  logic [1:0]       rk_r, rk_nxt;     // rank being emitted during an end, 0 = none
  logic             take, full;
  logic [1:0]       pos;
  logic             ins;

  assign full = (seen_r >= IdxW'(MAX_RECORDS));
  assign in_ready = q_room && (rk_r == 2'd0);
  assign take = in_valid && in_ready;

  always_comb begin
    pos = 2'd0;
    ins = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!ins && i < TOP_RANKS && (2'(i) >= fill_r || in_cmd.volume > vol_r[i])) begin
        ins = 1'b1;
        pos = 2'(i);
      end
    end
    if (in_cmd.volume == 32'd0) ins = 1'b0;
  end

  always_comb begin
    seen_nxt = seen_r;
    fill_nxt = fill_r;
    rk_nxt = rk_r;
    for (int i = 0; i < 3; i++) begin
      vol_nxt[i] = vol_r[i];
      idx_nxt[i] = idx_r[i];
    end
    q_push = 1'b0;
    q_data = '0;
    if (rk_r != 2'd0) begin
      if (q_room) begin
        q_push = 1'b1;
        q_data.kind = KIND_RANK;
        q_data.rank = rk_r;
        q_data.record_index = (2'(rk_r - 2'd1) < fill_r) ? idx_r[rk_r - 2'd1] : '0;
        q_data.last = (32'(rk_r) >= 32'(TOP_RANKS));
        if (q_data.last) begin
          rk_nxt = 2'd0;
          seen_nxt = '0;
          fill_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            vol_nxt[i] = '0;
            idx_nxt[i] = '0;
          end
        end else begin
          rk_nxt = rk_r + 2'd1;
        end
      end
    end else if (take) begin
      if (!in_cmd.is_end) begin
        if (!full) begin
          q_push = 1'b1;
          q_data.kind = KIND_RECORD;
          q_data.price_single_bits = to_single(in_cmd.price_bits);
          q_data.volume_out = in_cmd.volume;
          q_data.auxiliary_out = in_cmd.auxiliary;
          q_data.record_index = seen_r;
          seen_nxt = seen_r + 1'b1;
          if (ins) begin
            for (int i = 2; i > 0; i--) begin
              if (2'(i) > pos) begin
                vol_nxt[i] = vol_r[i-1];
                idx_nxt[i] = idx_r[i-1];
              end
            end
            vol_nxt[pos] = in_cmd.volume;
            idx_nxt[pos] = seen_r;
            if (32'(fill_r) < 32'(TOP_RANKS)) fill_nxt = fill_r + 2'd1;
          end
        end
      end else if (seen_r == '0) begin
        fill_nxt = '0;
        for (int i = 0; i < 3; i++) begin
          vol_nxt[i] = '0;
          idx_nxt[i] = '0;
        end
      end else if (fill_r != 2'd0) begin
        // rank 1 exists: emit it now; further ranks follow through rk_r when TOP_RANKS > 1
        q_push = 1'b1;
        q_data.kind = KIND_RANK;
        q_data.rank = 2'd1;
        q_data.record_index = idx_r[0];
        q_data.last = (TOP_RANKS == 1);
        if (TOP_RANKS == 1) begin
          seen_nxt = '0;
          fill_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            vol_nxt[i] = '0;
            idx_nxt[i] = '0;
          end
        end else rk_nxt = 2'd2;
      end else if (TOP_RANKS > 1) begin
        rk_nxt = 2'd2;
      end else begin
        seen_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      fill_r <= '0;
      rk_r <= '0;
      for (int i = 0; i < 3; i++) begin
        vol_r[i] <= '0;
        idx_r[i] <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      fill_r <= fill_nxt;
      rk_r <= rk_nxt;
      for (int i = 0; i < 3; i++) begin
        vol_r[i] <= vol_nxt[i];
        idx_r[i] <= idx_nxt[i];
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/drtp_queue.sv
// two-entry result queue between the front end and the output port
// depends on drtp_pkg
`default_nettype none
module drtp_queue
  import drtp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  res_t      din,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      dout
);
  res_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign room = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign dout = mem_r[rp_r];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/depth_record_top3_projector_top.sv
// channel | dir | tdata (low bit up)                                   | tuser
// in_     | in  | price_bits 64, volume 32, auxiliary 16 (112 bits)    | command
// out_    | out | price_single_bits 32, volume_out 32, auxiliary_out 16,
//         |     | record_index 10, rank 2 (96 bits)                     | kind; tlast = last
// one record per cycle while the queue has room; after an end with ranks, in_tready stays
// low while the remaining rank beats go out, set by the rank sequencer in the front end
// a two-entry queue parts front end and output; output stalls back up into in_tready
// rst_n is synchronous and clears the top list, counters and queue
`default_nettype none
module depth_record_top3_projector_top
  import drtp_pkg::*;
#(
  parameter int MAX_RECORDS = MaxRecordsDef,
  parameter int TOP_RANKS = TopRanksDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // price_bits, volume, auxiliary
  input  wire logic         in_tuser,   // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata, // price_single_bits, volume_out, auxiliary_out,
                                       // record_index, rank
  output logic              out_tuser,  // kind
  output logic              out_tlast   // last
);
  cmd_t cmd;
  res_t qd, qo;
  logic push, room;

  assign cmd.is_end = in_tuser;
  assign cmd.price_bits = in_tdata[63:0];
  assign cmd.volume = in_tdata[95:64];
  assign cmd.auxiliary = in_tdata[111:96];

  drtp_front #(.MAX_RECORDS(MAX_RECORDS), .TOP_RANKS(TOP_RANKS)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(cmd),
    .q_push(push), .q_data(qd), .q_room(room)
  );

  drtp_queue u_queue (
    .clk, .rst_n, .push, .din(qd), .room, .out_valid(out_tvalid),
    .out_ready(out_tready), .dout(qo)
  );

  assign out_tdata = {4'd0, qo.rank, qo.record_index, qo.auxiliary_out,
                      qo.volume_out, qo.price_single_bits};
  assign out_tuser = qo.kind;
  assign out_tlast = qo.last;
endmodule
`default_nettype wire

FILE: tb/sv/tb_depth_record_top3_projector_top.sv
// testbench for the depth record top-3 projector: record projection and rank beats
// depends on drtp_pkg and depth_record_top3_projector_top
`timescale 1ns / 100ps
module tb_depth_record_top3_projector_top;
  import drtp_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] price;
    logic [31:0] vol;
    logic [15:0] aux;
    logic [9:0]  idx;
    logic [1:0]  rank;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  bit timed_out = 0;

  beat_t expected_beats[$];

  // side state mirrored from the block
  int unsigned side_count;
  logic [31:0] best_vol[3];
  logic [9:0]  best_idx[3];
  int unsigned best_fill;

  always #10 clk = ~clk;

  depth_record_top3_projector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  function automatic logic [31:0] f64_to_f32(input logic [63:0] b);
    logic        sg;
    logic [10:0] ex;
    logic [52:0] man;
    logic [52:0] kp;
    logic [52:0] rmd;
    logic [52:0] hlf;
    int          e;
    int          sh;
    sg = b[63];
    ex = b[62:52];
    man = {1'b1, b[51:0]};
    if (ex == 11'h7ff) begin
      if (b[51:0] == 0) return {sg, 31'h7f800000};
      return {sg, 31'h7fc00000} | {9'd0, b[51:29]};
    end
    if (ex == 0) return {sg, 31'd0};
    e = int'(ex) - 896;
    if (e >= 255) return {sg, 31'h7f800000};
    if (e >= 1) begin
      kp = man >> 29;
      rmd = man & 53'h1fffffff;
      if (rmd > 53'h10000000 || (rmd == 53'h10000000 && kp[0])) kp++;
      if (kp == 53'h1000000) begin
        kp >>= 1;
        e++;
      end
      if (e >= 255) return {sg, 31'h7f800000};
      return {sg, 8'(e), kp[22:0]};
    end
    sh = 30 - e;
    if (sh > 63) return {sg, 31'd0};
    kp = (sh > 52) ? 53'd0 : man >> sh;
    rmd = (sh > 52) ? man : man & ((53'd1 << sh) - 1);
    hlf = (sh - 1 > 52) ? 53'd0 : 53'd1 << (sh - 1);
    if (sh - 1 > 52) return {sg, 31'd0};
    if (rmd > hlf || (rmd == hlf && kp[0])) kp++;
    return {sg, kp[30:0]};
  endfunction

  task automatic clear_side();
    side_count = 0;
    best_fill = 0;
    for (int i = 0; i < 3; i++) begin
      best_vol[i] = 0;
      best_idx[i] = 0;
    end
  endtask

  task automatic rank_insert(input logic [31:0] v, input logic [9:0] ix);
    int p;
    int s;
    p = 0;
    if (v == 0) return;
    while (p < best_fill && v <= best_vol[p]) p++;
    if (p >= 3) return;
    s = (best_fill < 3) ? best_fill : 2;
    while (s > p) begin
      best_vol[s] = best_vol[s-1];
      best_idx[s] = best_idx[s-1];
      s--;
    end
    best_vol[p] = v;
    best_idx[p] = ix;
    if (best_fill < 3) best_fill++;
  endtask

  task automatic predict_beats(input logic cmd, input logic [63:0] pr, input logic [31:0] v,
                               input logic [15:0] ax);
    beat_t b;
    int n;
    if (!cmd) begin
      if (side_count >= 1000) return;
      b = '{KIND_RECORD, f64_to_f32(pr), v, ax, 10'(side_count), 2'd0, 1'b0};
      expected_beats.insert(expected_beats.size(), b);
      rank_insert(v, 10'(side_count));
      side_count++;
      return;
    end
    n = 0;
    if (side_count > 0) begin
      for (int r = 0; r < 3; r++) begin
        if (r >= best_fill && r == 0) continue;
        b = '{KIND_RANK, 32'd0, 32'd0, 16'd0, (r < best_fill) ? best_idx[r] : 10'd0,
              2'(r + 1), 1'b0};
        expected_beats.insert(expected_beats.size(), b);
        n++;
      end
      if (n > 0) expected_beats[$].last = 1'b1;
    end
    clear_side();
  endtask

  // valid stays up into the next beat; idle cycles and drain drop it
  task automatic send_item(input logic cmd, input logic [63:0] pr, input logic [31:0] v,
                           input logic [15:0] ax);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {ax, v, pr};
    predict_beats(cmd, pr, v, ax);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{kind_t'(out_tuser), out_tdata[31:0], out_tdata[63:32], out_tdata[79:64],
              out_tdata[89:80], out_tdata[91:90], out_tlast};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: kind %0d/%0d price %h/%h vol %h/%h aux %h/%h ",
                      "idx %0d/%0d rank %0d/%0d last %0d/%0d"},
                     want.kind, got.kind, want.price, got.price, want.vol, got.vol,
                     want.aux, got.aux, want.idx, got.idx, want.rank, got.rank,
                     want.last, got.last);
        end
      end
    end
  end

  function automatic logic [63:0] rand_price();
    logic [63:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(5))
      0: p[62:52] = 11'(896 - $urandom_range(30));
      1: p[62:52] = 11'(1150 + $urandom_range(10));
      2: p[62:52] = 11'(1023 + $urandom_range(100) - 50);
      3: p[28:0] = ($urandom_range(1)) ? 29'h10000000 : 29'h0fffffff;
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed();
    send_item(1'b1, 64'd0, 32'd0, 16'd0);                    // empty side
    send_item(1'b0, 64'd0, 32'd0, 16'hffff);                 // zero volume only
    send_item(1'b1, 64'd0, 32'd0, 16'd0);
    send_item(1'b0, 64'h7ff0000000000000, 32'hffffffff, 16'd0);
    send_item(1'b0, 64'hfff8000000000001, 32'd5, 16'h1234);  // nan
    send_item(1'b0, 64'h47f0000000000000, 32'd5, 16'h8000);  // overflow
    send_item(1'b0, 64'h36a0000000000000, 32'd0, 16'd1);     // f32 subnormal
    send_item(1'b0, 64'h800fffffffffffff, 32'd7, 16'd2);     // f64 subnormal
    send_item(1'b0, 64'h3ff0000010000000, 32'd7, 16'd3);     // tie to even
    send_item(1'b0, 64'h3ff0000030000000, 32'd9, 16'd4);     // tie up
    send_item(1'b0, 64'h47efffffefffffff, 32'd1, 16'd5);
    send_item(1'b1, 64'hffffffffffffffff, 32'hffffffff, 16'hffff);
    send_item(1'b0, 64'hbff8000000000000, 32'd3, 16'd0);     // single candidate
    send_item(1'b1, 64'd0, 32'd0, 16'd0);
    send_item(1'b0, 64'h3810000000000000, 32'd2, 16'd0);
    send_item(1'b0, 64'h380fffffffffffff, 32'd8, 16'd0);
    send_item(1'b1, 64'd0, 32'd0, 16'd0);
  endtask

  task automatic test_random(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) begin
        send_item(1'b0, rand_price(),
                  ($urandom_range(3) == 0) ? 32'd0 :
                  ($urandom_range(1) ? 32'($urandom_range(4)) : $urandom),
                  16'($urandom));
        sent++;
      end
      send_item(1'b1, {$urandom, $urandom}, $urandom, 16'($urandom));
      sent++;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clear_side();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 60;
    test_directed();
    test_random(150);
    send_idle_pct = 60;
    recv_idle_pct = 33;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    drain();
    if (mismatches == 0 && !timed_out) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    timed_out = 1;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: files.f
rtl/drtp_pkg.sv
rtl/drtp_front.sv
rtl/drtp_queue.sv
rtl/depth_record_top3_projector_top.sv
tb/sv/tb_depth_record_top3_projector_top.sv
